### src/tpt_pkg.sv
`default_nettype none

package tpt_pkg;

	// sizing
	localparam int MAX_NODES    = 64;
	localparam int MAX_DEGREE   = 64;
	localparam int STACK_DEPTH  = 128;
	localparam int RESULT_LIMIT = 64;

	localparam int OP_W      = 2;
	localparam int NODE_W    = 7;
	localparam int NIDX_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int DIDX_W    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int DEG_W     = $clog2(MAX_DEGREE + 1);
	localparam int NBR_DEPTH = MAX_NODES * MAX_DEGREE;
	localparam int NBR_AW    = $clog2(NBR_DEPTH);
	localparam int STK_AW    = $clog2(STACK_DEPTH);
	localparam int TOP_W     = $clog2(STACK_DEPTH + 1);
	localparam int CNT_W     = $clog2(RESULT_LIMIT + 1);

	typedef logic [NODE_W-1:0] node_t;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_WALK  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// stack entry: {visited, parent, node}
	typedef struct packed {
		logic  vis;
		node_t par;
		node_t node;
	} stk_ent_t;

	typedef enum logic [1:0] {
		SEL_A,
		SEL_B,
		SEL_CUR
	} deg_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ADD_B_WR,
		S_ADD_A_RD,
		S_ADD_A_WR,
		S_RUN_CHK,
		S_ENTRY,
		S_DEG_WAIT,
		S_NB_RD,
		S_NB_CHK,
		S_FOUND,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic     load_in;
		logic     clear;
		logic     mark_lost;
		logic     deg_rd;
		deg_sel_t deg_sel;
		logic     append;
		logic     append_b;
		logic     run_init;
		logic     push_start;
		logic     pop;
		logic     push_self;
		logic     nb_init;
		logic     nb_rd;
		logic     nb_push;
		logic     set_ovf;
		logic     found;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic a_ok;
		logic b_ok;
		logic top_zero;
		logic stack_full;
		logic count_full;
		logic ent_vis;
		logic cnt_zero;
		logic nb_is_par;
		logic pend_valid;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

### src/tpt_req_if.sv
`default_nettype none

interface tpt_req_if import tpt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [NODE_W-1:0] node_a;
	logic [NODE_W-1:0] node_b;

	modport source (output valid, output op, output node_a, output node_b, input ready);
	modport sink   (input valid, input op, input node_a, input node_b, output ready);
endinterface

`default_nettype wire

### src/tpt_rsp_if.sv
`default_nettype none

interface tpt_rsp_if import tpt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] node;
	logic              last;
	logic              error;

	modport source (output valid, output node, output last, output error, input ready);
	modport sink   (input valid, input node, input last, input error, output ready);
endinterface

`default_nettype wire

### src/tree_postorder_traversal_top.sv
`default_nettype none

// Sequence: each request runs to completion before the next one is accepted. A walk
//   expands a node by reading its list entries one by one and finds it when its marker
//   pops; the first transfer follows the second node found or the run's end.
// Throughput: one request at a time.
// Reset: asynchronous, active low; controller idles, walk stack empty, all
//   degree lists read as empty through per-node valid flags, no clearing pass.
module tree_postorder_traversal_top import tpt_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	tpt_req_if.sink   req,
	tpt_rsp_if.source rsp
);

	// Controller and datapath talk only through these two groups.
	cmd_t cmd;
	sts_t sts;

	// The controller sequences each request: clear, the two halves of an
	// edge append (owner b first, then owner a), or the iterative walk
	// (pop, expand into self marker plus children, emit on marker pop).
	tpt_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the degree table, neighbour lists and walk stack,
	// plus a one-deep hold for the newest result so that the final transfer
	// can carry last and error once the run ends. The output register lets
	// the next request in while a result still waits on the sink.
	tpt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_op     (req.op),
		.in_node_a (req.node_a),
		.in_node_b (req.node_b),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_node  (rsp.node),
		.out_last  (rsp.last),
		.out_error (rsp.error)
	);

endmodule

`default_nettype wire

### src/tpt_ctl.sv
`default_nettype none

module tpt_ctl import tpt_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op)
					OP_CLEAR: begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end
					OP_ADD: begin
						if (!sts.a_ok || !sts.b_ok) begin
							cmd.mark_lost = 1'b1;
							state_d       = S_IDLE;
						end else begin
							cmd.deg_rd  = 1'b1;
							cmd.deg_sel = SEL_B;
							state_d     = S_ADD_B_WR;
						end
					end
					OP_WALK: begin
						cmd.run_init = 1'b1;
						if (!sts.a_ok) begin
							state_d = S_FINISH;
						end else begin
							cmd.push_start = 1'b1;
							state_d        = S_RUN_CHK;
						end
					end
					OP_NOP: begin
						state_d = S_IDLE;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_ADD_B_WR: begin
				// owner b takes a
				cmd.append   = 1'b1;
				cmd.append_b = 1'b1;
				state_d      = S_ADD_A_RD;
			end
			S_ADD_A_RD: begin
				// separate cycle so a self loop sees the updated length
				cmd.deg_rd  = 1'b1;
				cmd.deg_sel = SEL_A;
				state_d     = S_ADD_A_WR;
			end
			S_ADD_A_WR: begin
				cmd.append = 1'b1;
				state_d    = S_IDLE;
			end
			S_RUN_CHK: begin
				if (sts.top_zero || sts.count_full) begin
					state_d = S_FINISH;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_ENTRY;
				end
			end
			S_ENTRY: begin
				if (sts.ent_vis) begin
					state_d = S_FOUND;
				end else if (sts.stack_full) begin
					cmd.set_ovf = 1'b1;
					state_d     = S_FINISH;
				end else begin
					cmd.push_self = 1'b1;
					cmd.deg_rd    = 1'b1;
					cmd.deg_sel   = SEL_CUR;
					state_d       = S_DEG_WAIT;
				end
			end
			S_DEG_WAIT: begin
				cmd.nb_init = 1'b1;
				state_d     = S_NB_RD;
			end
			S_NB_RD: begin
				if (sts.cnt_zero) begin
					state_d = S_RUN_CHK;
				end else begin
					cmd.nb_rd = 1'b1;
					state_d   = S_NB_CHK;
				end
			end
			S_NB_CHK: begin
				if (sts.nb_is_par) begin
					state_d = S_NB_RD;
				end else if (sts.stack_full) begin
					cmd.set_ovf = 1'b1;
					state_d     = S_FINISH;
				end else begin
					cmd.nb_push = 1'b1;
					state_d     = S_NB_RD;
				end
			end
			S_FOUND: begin
				if (!sts.pend_valid || sts.out_free) begin
					cmd.found = 1'b1;
					state_d   = S_RUN_CHK;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### src/tpt_dp.sv
`default_nettype none

module tpt_dp import tpt_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire cmd_t          cmd,
	output sts_t               sts,
	input  wire [OP_W-1:0]     in_op,
	input  wire [NODE_W-1:0]   in_node_a,
	input  wire [NODE_W-1:0]   in_node_b,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [NODE_W-1:0]  out_node,
	output logic               out_last,
	output logic               out_error
);

	// captured request
	logic [OP_W-1:0] op_q;
	node_t           a_q;
	node_t           b_q;

	// control state
	logic                 lost_q;
	logic                 ovf_q;
	logic [TOP_W-1:0]     top_q;
	logic [CNT_W-1:0]     count_q;
	logic                 pend_vld_q;
	logic                 out_valid_q;
	logic [MAX_NODES-1:0] deg_vld_q;

	// payload registers
	node_t            pend_q;
	logic [DEG_W-1:0] cnt_q;
	logic [NIDX_W-1:0] deg_idx_q;
	logic [DEG_W-1:0] deg_rd_q;
	logic             deg_hit_q;
	node_t            nbr_rd_q;
	stk_ent_t         stk_rd_q;
	node_t            node_q;
	logic             last_q;
	logic             error_q;

	// memories
	logic [DEG_W-1:0] deg_mem [MAX_NODES];
	node_t            nbr_mem [NBR_DEPTH];
	stk_ent_t         stk_mem [STACK_DEPTH];

	logic              a_ok;
	logic              b_ok;
	logic [NIDX_W-1:0] a_idx;
	logic [NIDX_W-1:0] b_idx;
	logic [NIDX_W-1:0] cur_idx;
	logic [NIDX_W-1:0] deg_addr;
	logic [DEG_W-1:0]  deg_val;
	logic              deg_room;
	node_t             app_val;
	logic [NBR_AW-1:0] app_addr;
	logic [DEG_W-1:0]  cnt_m1;
	logic [NBR_AW-1:0] nb_addr;
	logic [TOP_W-1:0]  top_m1;
	logic              push;
	stk_ent_t          push_ent;
	logic              emit;
	logic              fin_err;

	assign a_ok    = (a_q != '0) && (a_q <= NODE_W'(MAX_NODES));
	assign b_ok    = (b_q != '0) && (b_q <= NODE_W'(MAX_NODES));
	assign a_idx   = NIDX_W'(a_q - NODE_W'(1));
	assign b_idx   = NIDX_W'(b_q - NODE_W'(1));
	assign cur_idx = NIDX_W'(stk_rd_q.node - NODE_W'(1));

	always_comb begin
		case (cmd.deg_sel)
			SEL_A:   deg_addr = a_idx;
			SEL_B:   deg_addr = b_idx;
			SEL_CUR: deg_addr = cur_idx;
			default: deg_addr = cur_idx;
		endcase
	end

	// an entry never written since clear reads as empty
	assign deg_val  = deg_hit_q ? deg_rd_q : '0;
	assign deg_room = deg_val < DEG_W'(MAX_DEGREE);
	assign app_val  = cmd.append_b ? a_q : b_q;
	assign app_addr = NBR_AW'(deg_idx_q) * NBR_AW'(MAX_DEGREE) + NBR_AW'(DIDX_W'(deg_val));

	assign cnt_m1  = cnt_q - DEG_W'(1);
	assign nb_addr = NBR_AW'(cur_idx) * NBR_AW'(MAX_DEGREE) + NBR_AW'(DIDX_W'(cnt_m1));
	assign top_m1  = top_q - TOP_W'(1);

	assign push = cmd.push_start || cmd.push_self || cmd.nb_push;

	always_comb begin
		push_ent = '{vis: 1'b0, par: '0, node: a_q};
		if (cmd.push_self) begin
			push_ent = '{vis: 1'b1, par: stk_rd_q.par, node: stk_rd_q.node};
		end else if (cmd.nb_push) begin
			push_ent = '{vis: 1'b0, par: stk_rd_q.node, node: nbr_rd_q};
		end
	end

	assign emit    = (cmd.found && pend_vld_q) || cmd.finish;
	assign fin_err = lost_q || ovf_q || (top_q != '0) || !a_ok;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lost_q      <= 1'b0;
			ovf_q       <= 1'b0;
			top_q       <= '0;
			count_q     <= '0;
			pend_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
			deg_vld_q   <= '0;
		end else begin
			if (cmd.clear) begin
				lost_q    <= 1'b0;
				deg_vld_q <= '0;
			end
			if (cmd.mark_lost) begin
				lost_q <= 1'b1;
			end
			if (cmd.append) begin
				if (deg_room) begin
					deg_vld_q[deg_idx_q] <= 1'b1;
				end else begin
					lost_q <= 1'b1;
				end
			end
			if (cmd.run_init) begin
				// start node goes into slot zero in the same cycle
				ovf_q      <= 1'b0;
				top_q      <= cmd.push_start ? TOP_W'(1) : '0;
				count_q    <= '0;
				pend_vld_q <= 1'b0;
			end else if (push) begin
				top_q <= top_q + TOP_W'(1);
			end else if (cmd.pop) begin
				top_q <= top_m1;
			end else if (cmd.finish) begin
				top_q <= '0;
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.found) begin
				pend_vld_q <= 1'b1;
				count_q    <= count_q + CNT_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= in_op;
			a_q  <= in_node_a;
			b_q  <= in_node_b;
		end
		if (cmd.deg_rd) begin
			deg_idx_q <= deg_addr;
			deg_hit_q <= deg_vld_q[deg_addr];
		end
		if (cmd.nb_init) begin
			cnt_q <= deg_val;
		end else if (cmd.nb_rd) begin
			cnt_q <= cnt_m1;
		end
		if (cmd.found) begin
			pend_q <= stk_rd_q.node;
		end
		if (emit) begin
			node_q  <= cmd.finish ? (pend_vld_q ? pend_q : '0) : pend_q;
			last_q  <= cmd.finish;
			error_q <= cmd.finish && fin_err;
		end
	end

	// degree lengths
	always_ff @(posedge clk) begin
		if (cmd.append && deg_room) begin
			deg_mem[deg_idx_q] <= deg_val + DEG_W'(1);
		end
		if (cmd.deg_rd) begin
			deg_rd_q <= deg_mem[deg_addr];
		end
	end

	// neighbour lists
	always_ff @(posedge clk) begin
		if (cmd.append && deg_room) begin
			nbr_mem[app_addr] <= app_val;
		end
		if (cmd.nb_rd) begin
			nbr_rd_q <= nbr_mem[nb_addr];
		end
	end

	// walk stack
	always_ff @(posedge clk) begin
		if (push) begin
			stk_mem[top_q[STK_AW-1:0]] <= push_ent;
		end
		if (cmd.pop) begin
			stk_rd_q <= stk_mem[top_m1[STK_AW-1:0]];
		end
	end

	always_comb begin
		sts            = '0;
		sts.op         = op_t'(op_q);
		sts.a_ok       = a_ok;
		sts.b_ok       = b_ok;
		sts.top_zero   = (top_q == '0);
		sts.stack_full = (top_q == TOP_W'(STACK_DEPTH));
		sts.count_full = (count_q == CNT_W'(RESULT_LIMIT));
		sts.ent_vis    = stk_rd_q.vis;
		sts.cnt_zero   = (cnt_q == '0);
		sts.nb_is_par  = (nbr_rd_q == stk_rd_q.par);
		sts.pend_valid = pend_vld_q;
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_node  = node_q;
	assign out_last  = last_q;
	assign out_error = error_q;

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push && !cmd.run_init |-> top_q < TOP_W'(STACK_DEPTH))
		else $error("push onto full walk stack");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> top_q != '0)
		else $error("pop from empty walk stack");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || out_ready))
		else $error("result overwrites an untaken transfer");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.found |-> count_q < CNT_W'(RESULT_LIMIT))
		else $error("result count past limit");

endmodule

`default_nettype wire

### bench/tree_postorder_traversal_top_tb.sv
module tree_postorder_traversal_top_tb import tpt_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// Random part length, idle cycles before the watchdog trips, and the
	// settling time once every expected node has been seen.
	localparam int RAND_ITEMS  = 260;
	localparam int STALL_LIMIT = 20000;
	localparam int TAIL_CYCLES = 64;
	localparam int IDLE_PCT    = 17;

	// One expected result of a walk.
	typedef struct packed {
		node_t node;
		logic  last;
		logic  error;
	} visit_t;

	logic clk;
	logic arst_n;

	tpt_req_if req_ch ();
	tpt_rsp_if rsp_ch ();

	tree_postorder_traversal_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow of the graph held by the block: neighbour lists in insertion
	// order, their lengths, and the sticky lost-edge flag.
	int unsigned list_len [1:MAX_NODES];
	node_t       adj_list [1:MAX_NODES][0:MAX_DEGREE-1];
	bit          edge_dropped;

	// Post-order nodes still owed by the block, oldest first.
	visit_t      postorder_q [$];

	int          fault_count;
	int          items_sent;
	bit          steady_flow;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Both sides idle at random about 17 percent of the time, except while the
	// steady stretch runs back-to-back transfers.
	function automatic bit take_break();
		return !steady_flow && ($urandom_range(99) < IDLE_PCT);
	endfunction

	function automatic bit node_valid(node_t n);
		return (n >= 1) && (n <= MAX_NODES);
	endfunction

	function automatic node_t bad_node();
		return ($urandom_range(3) == 0) ? node_t'(0) : node_t'($urandom_range(127, 65));
	endfunction

	function automatic node_t any_node();
		return node_t'($urandom_range(127));
	endfunction

	//------------------------------------------------------------------
	// Graph shadow
	//------------------------------------------------------------------
	function automatic void graph_clear();
		for (int i = 1; i <= MAX_NODES; i++)
			list_len[i] = 0;
		edge_dropped = 1'b0;
	endfunction

	function automatic void list_append(node_t owner, node_t value);
		if (list_len[owner] >= MAX_DEGREE) begin
			edge_dropped = 1'b1;
		end else begin
			adj_list[owner][list_len[owner]] = value;
			list_len[owner]++;
		end
	endfunction

	// An edge to a bad endpoint is lost whole; otherwise b's half goes first
	// and each half is dropped on its own if that list is full.
	function automatic void graph_add_edge(node_t a, node_t b);
		if (!node_valid(a) || !node_valid(b)) begin
			edge_dropped = 1'b1;
		end else begin
			list_append(b, a);
			list_append(a, b);
		end
	endfunction

	// Iterative DFS with {visited, parent, node} entries; a visited entry
	// popped off the stack is the next post-order node.
	function automatic void walk_postorder(node_t start);
		stk_ent_t stk [STACK_DEPTH];
		stk_ent_t ent;
		visit_t   run [$];
		visit_t   tail;
		int       sp;
		bit       bad;
		bit       ovf;

		bad = edge_dropped;
		ovf = 1'b0;
		sp  = 0;
		if (!node_valid(start)) begin
			bad = 1'b1;
		end else begin
			stk[0] = '{vis: 1'b0, par: node_t'(0), node: start};
			sp = 1;
			while (sp > 0 && run.size() < RESULT_LIMIT && !ovf) begin
				sp--;
				ent = stk[sp];
				if (ent.vis) begin
					run.push_back('{node: ent.node, last: 1'b0, error: 1'b0});
					continue;
				end
				if (sp >= STACK_DEPTH) begin
					ovf = 1'b1;
					break;
				end
				stk[sp] = '{vis: 1'b1, par: ent.par, node: ent.node};
				sp++;
				// pushed in reverse so the first inserted child pops first
				for (int p = int'(list_len[ent.node]) - 1; p >= 0; p--) begin
					if (adj_list[ent.node][p] != ent.par) begin
						if (sp >= STACK_DEPTH) begin
							ovf = 1'b1;
							break;
						end
						stk[sp] = '{vis: 1'b0, par: ent.node, node: adj_list[ent.node][p]};
						sp++;
					end
				end
			end
			if (ovf || sp > 0)
				bad = 1'b1;
		end

		if (run.size() == 0)
			run.push_back('{node: node_t'(0), last: 1'b0, error: 1'b0});
		tail       = run[run.size()-1];
		tail.last  = 1'b1;
		tail.error = bad;
		run[run.size()-1] = tail;
		foreach (run[i])
			postorder_q.push_back(run[i]);
	endfunction

	function automatic void graph_apply(op_t op, node_t a, node_t b);
		case (op)
			OP_CLEAR: graph_clear();
			OP_ADD:   graph_add_edge(a, b);
			OP_WALK:  walk_postorder(a);
			default:  ;
		endcase
	endfunction

	//------------------------------------------------------------------
	// Request side
	//------------------------------------------------------------------
	// valid stays high into the next call, which either holds it with new
	// fields or drops it for an idle gap - never both in one step.
	task automatic send_req(op_t op, node_t a, node_t b);
		while (take_break()) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.op     <= op;
		req_ch.node_a <= a;
		req_ch.node_b <= b;
		do
			@(posedge clk);
		while (!req_ch.ready);
		graph_apply(op, a, b);
		if (op != OP_NOP)
			items_sent++;
	endtask

	task automatic send_clear();
		send_req(OP_CLEAR, any_node(), any_node());
	endtask

	task automatic send_walk(node_t start);
		send_req(OP_WALK, start, any_node());
	endtask

	// Drop valid and wait for every owed node, then let the block settle.
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (postorder_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	//------------------------------------------------------------------
	// Directed tests
	//------------------------------------------------------------------
	// Walks on an empty graph: isolated nodes at both ends of the range, and
	// bad start ids, each giving a single result.
	task automatic test_empty_graph();
		send_walk(node_t'(1));
		send_walk(node_t'(MAX_NODES));
		send_walk(node_t'(0));
		send_walk(node_t'(65));
		send_walk(node_t'(127));
		send_req(OP_NOP, node_t'(127), node_t'(127));
		send_clear();
		settle();
	endtask

	// Small tree; child order follows insertion, walks from root, leaves and an isolated node.
	task automatic test_small_tree();
		send_req(OP_ADD, node_t'(1), node_t'(2));
		send_req(OP_ADD, node_t'(3), node_t'(1));
		send_req(OP_ADD, node_t'(2), node_t'(64));
		send_req(OP_ADD, node_t'(2), node_t'(5));
		send_req(OP_ADD, node_t'(6), node_t'(3));
		send_walk(node_t'(1));
		send_walk(node_t'(64));
		send_walk(node_t'(6));
		send_walk(node_t'(40));
		settle();
	endtask

	// Bad endpoints taint every walk until the next clear; a self loop
	// lands twice in its own list.
	task automatic test_bad_edges();
		send_clear();
		send_req(OP_ADD, node_t'(0), node_t'(5));
		send_req(OP_ADD, node_t'(5), node_t'(65));
		send_req(OP_ADD, node_t'(127), node_t'(127));
		send_walk(node_t'(5));
		send_clear();
		send_req(OP_ADD, node_t'(7), node_t'(7));
		send_req(OP_ADD, node_t'(7), node_t'(8));
		send_walk(node_t'(7));
		send_walk(node_t'(8));
		settle();
	endtask

	// 64 parallel edges fill both lists: the walk from 1 hits the result
	// limit, and one more edge is lost at both ends.
	task automatic test_full_list();
		send_clear();
		repeat (MAX_DEGREE)
			send_req(OP_ADD, node_t'(1), node_t'(2));
		send_walk(node_t'(1));
		send_req(OP_ADD, node_t'(1), node_t'(2));
		send_walk(node_t'(2));
		settle();
	endtask

	// A triangle lets the walk loop until the stack overflows: first with no
	// node given, then with a leaf given before the overflow.
	task automatic test_stack_overflow();
		send_clear();
		send_req(OP_ADD, node_t'(1), node_t'(2));
		send_req(OP_ADD, node_t'(2), node_t'(3));
		send_req(OP_ADD, node_t'(3), node_t'(1));
		send_walk(node_t'(1));
		send_clear();
		send_req(OP_ADD, node_t'(1), node_t'(4));
		send_req(OP_ADD, node_t'(1), node_t'(2));
		send_req(OP_ADD, node_t'(2), node_t'(3));
		send_req(OP_ADD, node_t'(3), node_t'(1));
		send_walk(node_t'(1));
		send_clear();
		settle();
	endtask

	//------------------------------------------------------------------
	// Random trees
	//------------------------------------------------------------------
	// Mostly well-formed trees on random labels, edges in random order and
	// orientation, then a few walks. Noise is sprinkled in: no-ops, bad
	// edges, extra edges that close cycles, early walks, skipped clears.
	task automatic test_random_trees();
		node_t labels [MAX_NODES];
		node_t ea [$];
		node_t eb [$];
		node_t tmp;
		node_t par;
		int    base;
		int    size;
		int    j;
		int    pick;

		base = items_sent;
		while (items_sent - base < RAND_ITEMS) begin
			steady_flow = (items_sent - base < 90);
			for (int i = 0; i < MAX_NODES; i++)
				labels[i] = node_t'(i + 1);
			for (int i = MAX_NODES - 1; i > 0; i--) begin
				j         = $urandom_range(i);
				tmp       = labels[i];
				labels[i] = labels[j];
				labels[j] = tmp;
			end
			size = ($urandom_range(9) == 0) ? $urandom_range(MAX_NODES, 20)
			                                : $urandom_range(12, 1);
			for (int i = 1; i < size; i++) begin
				par = labels[$urandom_range(i - 1)];
				if ($urandom_range(1)) begin
					ea.push_back(par);
					eb.push_back(labels[i]);
				end else begin
					ea.push_back(labels[i]);
					eb.push_back(par);
				end
			end

			if ($urandom_range(5) != 0)
				send_clear();
			while (ea.size() != 0) begin
				if ($urandom_range(11) == 0) begin
					case ($urandom_range(3))
						0: send_req(OP_NOP, any_node(), any_node());
						1: send_req(OP_ADD, bad_node(), node_t'($urandom_range(MAX_NODES, 1)));
						2: send_req(OP_ADD, labels[$urandom_range(size - 1)],
						            labels[$urandom_range(size - 1)]);
						default: send_walk(labels[0]);
					endcase
				end
				pick = $urandom_range(ea.size() - 1);
				send_req(OP_ADD, ea[pick], eb[pick]);
				ea.delete(pick);
				eb.delete(pick);
			end
			repeat ($urandom_range(3, 1)) begin
				if ($urandom_range(7) == 0)
					send_walk(bad_node());
				else
					send_walk(labels[$urandom_range(size - 1)]);
			end
		end
		steady_flow = 1'b0;
		settle();
	endtask

	//------------------------------------------------------------------
	// Result side: random back-pressure and in-order checking
	//------------------------------------------------------------------
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rsp_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin : result_check
		visit_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				if (postorder_q.size() == 0) begin
					$error("unexpected transfer: node %0d last %0b error %0b",
					       rsp_ch.node, rsp_ch.last, rsp_ch.error);
					fault_count++;
				end else begin
					want = postorder_q.pop_front();
					if (rsp_ch.node !== want.node) begin
						$error("node: expected %0d, got %0d", want.node, rsp_ch.node);
						fault_count++;
					end
					if (rsp_ch.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, rsp_ch.last);
						fault_count++;
					end
					if (rsp_ch.error !== want.error) begin
						$error("error: expected %0b, got %0b", want.error, rsp_ch.error);
						fault_count++;
					end
				end
			end
		end
	end

	// Trips when neither channel has seen a transfer for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	//------------------------------------------------------------------
	// Test sequence
	//------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.op     = OP_NOP;
		req_ch.node_a = '0;
		req_ch.node_b = '0;
		fault_count   = 0;
		items_sent    = 0;
		steady_flow   = 1'b0;
		graph_clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_graph();
		test_small_tree();
		test_bad_edges();
		test_full_list();
		test_stack_overflow();
		test_random_trees();

		if (fault_count == 0 && postorder_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			if (postorder_q.size() != 0)
				$error("%0d expected nodes never transferred", postorder_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
